FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mipbp_pkg.sv
// shared types and constants of the best point search block
package mipbp_pkg;

   // default sizes of the stores
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_MAX_DIMS   = 16;

   // field widths
   localparam int VALUE_W    = 16;
   localparam int PROD_W     = 32;
   localparam int UTIL_W     = 36;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int UNUM_W     = 16;
   localparam int DIMS_REG_W = 5;
   localparam int PTS_REG_W  = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 11;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0]  REG_NUM_DIMS   = 4'd0;
   localparam logic [CSR_IDX_W-1:0]  REG_NUM_POINTS = 4'd1;
   localparam logic [DIMS_REG_W-1:0] RST_NUM_DIMS   = 5'd16;
   localparam logic [PTS_REG_W-1:0]  RST_NUM_POINTS = 11'd1024;

   // transaction function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MARK_RD,
      ST_MARK_WR
   } state_type;

   // store port strobes
   typedef struct packed {
      logic pt_we;
      logic w_we;
      logic rd_en;
   } store_ctl_type;

   // chosen mark port strobes
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mark_ctl_type;

   // tag that travels with each scanned coordinate
   typedef struct packed {
      logic valid;
      logic first_d;
      logic last_d;
      logic last_pt;
   } scan_tag_type;

endpackage

FILE: hdl/max_inner_product_best_point.sv
// top level: best point search over a loaded point set
// point load or weight coordinate that does not close a vector: busy stays low
// closing weight coordinate: busy through the scan, drain and mark update, then a result
// strobe; the point store read port gives one coordinate per cycle
// after reset the chosen marks are cleared one entry per cycle and busy stays high until
// the clearing sweep ends; configuration writes are taken throughout
`include "assert_macros.svh"
module max_inner_product_best_point import mipbp_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int MAX_DIMS   = DEF_MAX_DIMS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   output logic [UNUM_W-1:0]     rsp_user_number,
   output logic [IDX_W-1:0]      rsp_best_index,
   output logic [UTIL_W-1:0]     rsp_best_utility,
   output logic                  rsp_newly_chosen,
   output logic [CNT_W-1:0]      rsp_chosen_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH = MAX_POINTS * MAX_DIMS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int PIW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PW    = $clog2(MAX_POINTS + 1);
   localparam int DAW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DW    = $clog2(MAX_DIMS + 1);

   state_type             state_ff;
   state_type             state_in;
   logic [DIMS_REG_W-1:0] num_dims_ff;
   logic [PTS_REG_W-1:0]  num_points_ff;
   logic [DW-1:0]         dims_eff;
   logic [PW-1:0]         pts_eff;
   logic [LW-1:0]         limit;
   logic [LW-1:0]         load_pos_ff;
   logic [DAW-1:0]        qpos_ff;
   logic [AW-1:0]         addr_ff;
   logic [DAW-1:0]        d_ff;
   logic [PIW-1:0]        j_ff;
   logic                  last_d;
   logic                  last_pt;
   scan_tag_type          tag_s1_ff;
   logic [PIW-1:0]        idx_s1_ff;
   logic                  accept;
   logic                  load_hit;
   logic                  q_acc;
   logic                  q_done;
   logic                  issue;
   store_ctl_type         store_ctl;
   mark_ctl_type          mark_ctl;
   logic [VALUE_W-1:0]    pt_rdata;
   logic [VALUE_W-1:0]    w_rdata;
   logic [PIW-1:0]        best_idx;
   logic [UTIL_W-1:0]     best_u;
   logic                  mac_done;
   logic                  mark_rd_data;
   logic                  marks_ready;
   logic                  fresh;
   logic [PW-1:0]         count_ff;
   logic [PW-1:0]         count_in;
   logic [UNUM_W-1:0]     qcnt_ff;
   logic                  rsp_valid_ff;
   logic [UNUM_W-1:0]     rsp_user_number_ff;
   logic [IDX_W-1:0]      rsp_best_index_ff;
   logic [UTIL_W-1:0]     rsp_best_utility_ff;
   logic                  rsp_newly_chosen_ff;
   logic [CNT_W-1:0]      rsp_chosen_count_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff   <= RST_NUM_DIMS;
         num_points_ff <= RST_NUM_POINTS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NUM_DIMS:   num_dims_ff   <= csr_data[DIMS_REG_W-1:0];
            REG_NUM_POINTS: num_points_ff <= csr_data[PTS_REG_W-1:0];
            default:        ;
         endcase
      end
   end

   // clamped sizes and store fill limit
   always_comb begin
      if (num_dims_ff == '0) begin
         dims_eff = DW'(1);
      end else if (int'(num_dims_ff) > MAX_DIMS) begin
         dims_eff = DW'(MAX_DIMS);
      end else begin
         dims_eff = DW'(num_dims_ff);
      end
      if (num_points_ff == '0) begin
         pts_eff = PW'(1);
      end else if (int'(num_points_ff) > MAX_POINTS) begin
         pts_eff = PW'(MAX_POINTS);
      end else begin
         pts_eff = PW'(num_points_ff);
      end
      limit = LW'(pts_eff) * LW'(dims_eff);
   end

   // input transaction decode
   assign accept   = start && !busy;
   assign load_hit = accept && (req_func == FUNC_LOAD) && (load_pos_ff < limit);
   assign q_acc    = accept && (req_func == FUNC_QUERY);
   assign q_done   = q_acc && ((DW'(qpos_ff) + DW'(1)) >= dims_eff);

   // scan position flags
   assign last_d  = (d_ff == DAW'(dims_eff - DW'(1)));
   assign last_pt = (j_ff == PIW'(pts_eff - PW'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (marks_ready) state_in = ST_IDLE;
         ST_IDLE:    if (q_done) state_in = ST_SCAN;
         ST_SCAN:    if (last_d && last_pt) state_in = ST_DRAIN;
         ST_DRAIN:   if (mac_done) state_in = ST_MARK_RD;
         ST_MARK_RD: state_in = ST_MARK_WR;
         ST_MARK_WR: state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      busy           = 1'b1;
      issue          = 1'b0;
      mark_ctl.rd_en = 1'b0;
      mark_ctl.wr_en = 1'b0;
      case (state_ff)
         ST_IDLE:    busy = 1'b0;
         ST_SCAN:    issue = 1'b1;
         ST_MARK_RD: mark_ctl.rd_en = 1'b1;
         ST_MARK_WR: mark_ctl.wr_en = !mark_rd_data;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // load and weight positions
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         qpos_ff     <= '0;
      end else begin
         if (load_hit) begin
            load_pos_ff <= load_pos_ff + LW'(1);
         end
         if (q_done) begin
            qpos_ff <= '0;
         end else if (q_acc) begin
            qpos_ff <= qpos_ff + DAW'(1);
         end
      end
   end

   // scan address generator
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         d_ff      <= '0;
         j_ff      <= '0;
         tag_s1_ff <= '0;
      end else begin
         if (q_done) begin
            addr_ff <= '0;
            d_ff    <= '0;
            j_ff    <= '0;
         end else if (issue) begin
            addr_ff <= addr_ff + AW'(1);
            if (last_d) begin
               d_ff <= '0;
               j_ff <= j_ff + PIW'(1);
            end else begin
               d_ff <= d_ff + DAW'(1);
            end
         end
         tag_s1_ff.valid   <= issue;
         tag_s1_ff.first_d <= (d_ff == '0);
         tag_s1_ff.last_d  <= last_d;
         tag_s1_ff.last_pt <= last_pt;
      end
   end

   always_ff @(posedge clock) begin
      idx_s1_ff <= j_ff;
   end

   // store access
   assign store_ctl.pt_we = load_hit;
   assign store_ctl.w_we  = q_acc;
   assign store_ctl.rd_en = issue;

   mipbp_store #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_store (
      .clock    (clock),
      .ctl      (store_ctl),
      .wdata    (req_value),
      .pt_waddr (AW'(load_pos_ff)),
      .w_waddr  (qpos_ff),
      .pt_raddr (addr_ff),
      .w_raddr  (d_ff),
      .pt_rdata (pt_rdata),
      .w_rdata  (w_rdata)
   );

   mipbp_mac #(
      .MAX_POINTS (MAX_POINTS)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .tag          (tag_s1_ff),
      .idx          (idx_s1_ff),
      .pt_data      (pt_rdata),
      .w_data       (w_rdata),
      .best_index   (best_idx),
      .best_utility (best_u),
      .done         (mac_done)
   );

   mipbp_marks #(
      .MAX_POINTS (MAX_POINTS)
   ) u_marks (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mark_ctl),
      .addr    (best_idx),
      .rd_data (mark_rd_data),
      .ready   (marks_ready)
   );

   // distinct count and query counter
   assign fresh    = !mark_rd_data;
   assign count_in = count_ff + PW'(fresh);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         qcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_MARK_WR);
         if (state_ff == ST_MARK_WR) begin
            count_ff <= count_in;
            qcnt_ff  <= qcnt_ff + UNUM_W'(1);
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_MARK_WR) begin
         rsp_user_number_ff  <= qcnt_ff;
         rsp_best_index_ff   <= IDX_W'(best_idx);
         rsp_best_utility_ff <= best_u;
         rsp_newly_chosen_ff <= fresh;
         rsp_chosen_count_ff <= CNT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_user_number  = rsp_user_number_ff;
   assign rsp_best_index   = rsp_best_index_ff;
   assign rsp_best_utility = rsp_best_utility_ff;
   assign rsp_newly_chosen = rsp_newly_chosen_ff;
   assign rsp_chosen_count = rsp_chosen_count_ff;

   // a closing weight coordinate starts a scan from the first store entry
   `ASSERT_NEXT(a_scan_start, clock, reset, q_done, (state_ff == ST_SCAN) && (addr_ff == '0),
      "scan did not start after closing weight coordinate")

   // the mark update always yields a result strobe and returns to idle
   `ASSERT_NEXT(a_rsp_after_mark, clock, reset, state_ff == ST_MARK_WR,
      rsp_valid_ff && (state_ff == ST_IDLE), "mark update without result transaction")

endmodule

FILE: hdl/mipbp_store.sv
// point coordinate store and weight vector store, with registered read ports
module mipbp_store import mipbp_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int MAX_DIMS   = DEF_MAX_DIMS,
   localparam int DEPTH     = MAX_POINTS * MAX_DIMS,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int DAW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic               clock,
   input  store_ctl_type      ctl,
   input  logic [VALUE_W-1:0] wdata,
   input  logic [AW-1:0]      pt_waddr,
   input  logic [DAW-1:0]     w_waddr,
   input  logic [AW-1:0]      pt_raddr,
   input  logic [DAW-1:0]     w_raddr,
   output logic [VALUE_W-1:0] pt_rdata,
   output logic [VALUE_W-1:0] w_rdata
);

   logic [VALUE_W-1:0] pt_mem [0:DEPTH-1];
   logic [VALUE_W-1:0] w_mem  [0:MAX_DIMS-1];
   logic [VALUE_W-1:0] pt_rdata_ff;
   logic [VALUE_W-1:0] w_rdata_ff;

   // point store port
   always_ff @(posedge clock) begin
      if (ctl.pt_we) begin
         pt_mem[pt_waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         pt_rdata_ff <= pt_mem[pt_raddr];
      end
   end

   // weight vector port
   always_ff @(posedge clock) begin
      if (ctl.w_we) begin
         w_mem[w_waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         w_rdata_ff <= w_mem[w_raddr];
      end
   end

   assign pt_rdata = pt_rdata_ff;
   assign w_rdata  = w_rdata_ff;

endmodule

FILE: hdl/mipbp_marks.sv
// chosen point marks with clearing sweep after reset
`include "assert_macros.svh"
module mipbp_marks import mipbp_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   localparam int PIW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  mark_ctl_type   ctl,
   input  logic [PIW-1:0] addr,
   output logic           rd_data,
   output logic           ready
);

   logic           mem [0:MAX_POINTS-1];
   logic           clr_active_ff;
   logic           clr_active_in;
   logic [PIW-1:0] clr_addr_ff;
   logic [PIW-1:0] clr_addr_in;
   logic           rd_data_ff;

   // clearing sweep counter
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + PIW'(1);
         if (clr_addr_ff == PIW'(MAX_POINTS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // mark memory: sweep clears, winner sets
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (ctl.wr_en) begin
         mem[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_active_ff;

   // no mark access may overlap the clearing sweep
   `ASSERT_ALWAYS(a_no_access_in_clear, clock, reset,
      !(clr_active_ff && (ctl.rd_en || ctl.wr_en)), "mark access during clearing sweep")

endmodule

FILE: hdl/mipbp_mac.sv
// multiply-accumulate of one point per pass and running argmax
`include "assert_macros.svh"
module mipbp_mac import mipbp_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   localparam int PIW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_tag_type       tag,
   input  logic [PIW-1:0]     idx,
   input  logic [VALUE_W-1:0] pt_data,
   input  logic [VALUE_W-1:0] w_data,
   output logic [PIW-1:0]     best_index,
   output logic [UTIL_W-1:0]  best_utility,
   output logic               done
);

   scan_tag_type        tag_a_ff;
   logic [PIW-1:0]      idx_a_ff;
   logic [PROD_W-1:0]   prod_ff;
   scan_tag_type        tag_b_ff;
   logic [PIW-1:0]      idx_b_ff;
   logic [UTIL_W-1:0]   acc_ff;
   logic [UTIL_W-1:0]   acc_in;
   logic [UTIL_W:0]     acc_sum;
   logic [PIW-1:0]      best_idx_ff;
   logic [PIW-1:0]      best_idx_in;
   logic [UTIL_W-1:0]   best_u_ff;
   logic [UTIL_W-1:0]   best_u_in;
   logic                done_ff;
   logic                done_in;

   // tag pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         tag_a_ff <= tag;
         tag_b_ff <= tag_a_ff;
         done_ff  <= done_in;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      prod_ff  <= PROD_W'(pt_data) * PROD_W'(w_data);
      idx_a_ff <= idx;
   end

   // saturating accumulate, restarting at the first coordinate of a point
   always_comb begin
      acc_sum = (tag_a_ff.first_d ? (UTIL_W + 1)'(0) : (UTIL_W + 1)'(acc_ff))
              + (UTIL_W + 1)'(prod_ff);
      acc_in  = acc_sum[UTIL_W] ? '1 : acc_sum[UTIL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (tag_a_ff.valid) begin
         acc_ff <= acc_in;
      end
      idx_b_ff <= idx_a_ff;
   end

   // compare a finished point with the best so far, lowest index wins ties
   always_comb begin
      best_idx_in = best_idx_ff;
      best_u_in   = best_u_ff;
      done_in     = 1'b0;
      if (tag_b_ff.valid && tag_b_ff.last_d) begin
         if (idx_b_ff == '0 || acc_ff > best_u_ff) begin
            best_idx_in = idx_b_ff;
            best_u_in   = acc_ff;
         end
         done_in = tag_b_ff.last_pt;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_u_ff   <= best_u_in;
   end

   assign best_index   = best_idx_ff;
   assign best_utility = best_u_ff;
   assign done         = done_ff;

   // the scan end shows up once per query
   `ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff, "scan done held longer than one cycle")

endmodule
